### sv/d2g_pkg.sv
// ============================================================================
// d2g_pkg
// shared constants, the output date type and the month table for the day number to
// gregorian date converter
// ============================================================================
package d2g_pkg;

    localparam int unsigned DAY_NUMBER_W = 22;
    localparam int unsigned YEAR_W       = 14;
    localparam int unsigned MONTH_W      = 4;
    localparam int unsigned DAY_W        = 5;

    // span lengths in days
    localparam logic [17:0] DAYS_400Y = 18'd146097;
    localparam logic [15:0] DAYS_100Y = 16'd36524;
    localparam logic [10:0] DAYS_4Y   = 11'd1461;
    localparam logic [8:0]  DAYS_1Y   = 9'd365;

    // reciprocals for constant division, estimate is never high and at most one low
    localparam logic [14:0] RECIP_400Y = 15'd29398;   // floor(2^32 / 146097)
    localparam int unsigned RECIP_400Y_SHIFT = 32;
    localparam logic [13:0] RECIP_4Y   = 14'd11483;   // floor(2^24 / 1461)
    localparam int unsigned RECIP_4Y_SHIFT = 24;

    // quotient at which year index within a century wraps to a century year
    localparam logic [4:0] Q4_CENTURY = 5'd24;

    // output bundle of the datapath
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               in_range;
    } d2g_date_t;

    // first day of month (0-based) within the year
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        begin
            case (idx)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            if (leap && (idx >= 4'd2))
            begin
                base = base + 9'd1;
            end
            return base;
        end
    endfunction

endpackage

### sv/d2g_pipe.sv
// ============================================================================
// d2g_pipe
// ten stage datapath splitting a day number into 400, 100, 4 and 1 year spans
// and then into month and day, all stages advance together on en
// ============================================================================
module d2g_pipe #(
    parameter logic [31:0] LAST_DAY = 32'd3652059
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [d2g_pkg::DAY_NUMBER_W-1:0]    day_number,
    output d2g_pkg::d2g_date_t                  date
);
    import d2g_pkg::*;

    // stage 1: range check, zero-based count, quotient estimate
    logic        p1_ok_reg;
    logic [21:0] p1_n_reg;
    logic [4:0]  p1_q_reg;
    logic [21:0] n_next;
    logic [36:0] q400_prod;

    assign n_next    = day_number - 22'd1;
    assign q400_prod = 37'(n_next) * 37'(RECIP_400Y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_ok_reg <= (day_number != '0) && ({10'd0, day_number} <= LAST_DAY);
            p1_n_reg  <= n_next;
            p1_q_reg  <= q400_prod[RECIP_400Y_SHIFT +: 5];
        end
    end

    // stage 2: remainder from the estimate, below twice DAYS_400Y
    logic        p2_ok_reg;
    logic [4:0]  p2_q_reg;
    logic [18:0] p2_r_reg;
    logic [22:0] q400_days;

    assign q400_days = 23'(p1_q_reg) * 23'(DAYS_400Y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_ok_reg <= p1_ok_reg;
            p2_q_reg  <= p1_q_reg;
            p2_r_reg  <= 19'(23'(p1_n_reg) - q400_days);
        end
    end

    // stage 3: correct the estimate
    logic        p3_ok_reg;
    logic [4:0]  p3_q400_reg;
    logic [17:0] p3_r_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_ok_reg <= p2_ok_reg;
            if (p2_r_reg >= 19'(DAYS_400Y))
            begin
                p3_q400_reg <= p2_q_reg + 5'd1;
                p3_r_reg    <= 18'(p2_r_reg - 19'(DAYS_400Y));
            end
            else
            begin
                p3_q400_reg <= p2_q_reg;
                p3_r_reg    <= p2_r_reg[17:0];
            end
        end
    end

    // stage 4: century within the cycle, saturated at 3 for the cycle's last day
    logic        p4_ok_reg;
    logic [4:0]  p4_q400_reg;
    logic [1:0]  p4_c_reg;
    logic [15:0] p4_r_reg;
    logic [1:0]  c_next;
    logic [17:0] c_days;

    always_comb
    begin
        if (p3_r_reg >= 18'(3 * DAYS_100Y))
        begin
            c_next = 2'd3;
            c_days = 18'(3 * DAYS_100Y);
        end
        else if (p3_r_reg >= 18'(2 * DAYS_100Y))
        begin
            c_next = 2'd2;
            c_days = 18'(2 * DAYS_100Y);
        end
        else if (p3_r_reg >= 18'(DAYS_100Y))
        begin
            c_next = 2'd1;
            c_days = 18'(DAYS_100Y);
        end
        else
        begin
            c_next = 2'd0;
            c_days = 18'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_ok_reg   <= p3_ok_reg;
            p4_q400_reg <= p3_q400_reg;
            p4_c_reg    <= c_next;
            p4_r_reg    <= 16'(p3_r_reg - c_days);
        end
    end

    // stage 5: four-year span estimate
    logic        p5_ok_reg;
    logic [4:0]  p5_q400_reg;
    logic [1:0]  p5_c_reg;
    logic [15:0] p5_r_reg;
    logic [4:0]  p5_q_reg;
    logic [29:0] q4_prod;

    assign q4_prod = 30'(p4_r_reg) * 30'(RECIP_4Y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_ok_reg   <= p4_ok_reg;
            p5_q400_reg <= p4_q400_reg;
            p5_c_reg    <= p4_c_reg;
            p5_r_reg    <= p4_r_reg;
            p5_q_reg    <= q4_prod[RECIP_4Y_SHIFT +: 5];
        end
    end

    // stage 6: remainder within the four-year span
    logic        p6_ok_reg;
    logic [4:0]  p6_q400_reg;
    logic [1:0]  p6_c_reg;
    logic [4:0]  p6_q_reg;
    logic [11:0] p6_r_reg;
    logic [15:0] q4_days;

    assign q4_days = 16'(p5_q_reg) * 16'(DAYS_4Y);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p6_ok_reg   <= p5_ok_reg;
            p6_q400_reg <= p5_q400_reg;
            p6_c_reg    <= p5_c_reg;
            p6_q_reg    <= p5_q_reg;
            p6_r_reg    <= 12'(p5_r_reg - q4_days);
        end
    end

    // stage 7: correct the span estimate
    logic        p7_ok_reg;
    logic [4:0]  p7_q400_reg;
    logic [1:0]  p7_c_reg;
    logic [4:0]  p7_q4_reg;
    logic [10:0] p7_r_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p7_ok_reg   <= p6_ok_reg;
            p7_q400_reg <= p6_q400_reg;
            p7_c_reg    <= p6_c_reg;
            if (p6_r_reg >= 12'(DAYS_4Y))
            begin
                p7_q4_reg <= p6_q_reg + 5'd1;
                p7_r_reg  <= 11'(p6_r_reg - 12'(DAYS_4Y));
            end
            else
            begin
                p7_q4_reg <= p6_q_reg;
                p7_r_reg  <= p6_r_reg[10:0];
            end
        end
    end

    // stage 8: single year, saturated at 3, then year and leap flag
    logic        p8_ok_reg;
    logic [13:0] p8_year_reg;
    logic        p8_leap_reg;
    logic [8:0]  p8_doy_reg;
    logic [1:0]  y1_next;
    logic [10:0] y1_days;
    logic [13:0] year_next;

    always_comb
    begin
        if (p7_r_reg >= 11'(3 * DAYS_1Y))
        begin
            y1_next = 2'd3;
            y1_days = 11'(3 * DAYS_1Y);
        end
        else if (p7_r_reg >= 11'(2 * DAYS_1Y))
        begin
            y1_next = 2'd2;
            y1_days = 11'(2 * DAYS_1Y);
        end
        else if (p7_r_reg >= 11'(DAYS_1Y))
        begin
            y1_next = 2'd1;
            y1_days = 11'(DAYS_1Y);
        end
        else
        begin
            y1_next = 2'd0;
            y1_days = 11'd0;
        end
    end

    assign year_next = 14'(p7_q400_reg) * 14'd400 + 14'(p7_c_reg) * 14'd100
                     + {7'd0, p7_q4_reg, 2'd0} + 14'(y1_next) + 14'd1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p8_ok_reg   <= p7_ok_reg;
            p8_year_reg <= year_next;
            // divisible by 4 only when y1 is 3, by 100 when the span is also the 25th
            p8_leap_reg <= (y1_next == 2'd3) && ((p7_q4_reg != Q4_CENTURY) || (p7_c_reg == 2'd3));
            p8_doy_reg  <= 9'(p7_r_reg - y1_days);
        end
    end

    // stage 9: month from the cumulative table
    logic        p9_ok_reg;
    logic [13:0] p9_year_reg;
    logic        p9_leap_reg;
    logic [8:0]  p9_doy_reg;
    logic [3:0]  p9_month_reg;
    logic [3:0]  month_next;

    always_comb
    begin
        month_next = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (p8_doy_reg >= month_start(4'(k), p8_leap_reg))
            begin
                month_next = 4'(k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p9_ok_reg    <= p8_ok_reg;
            p9_year_reg  <= p8_year_reg;
            p9_leap_reg  <= p8_leap_reg;
            p9_doy_reg   <= p8_doy_reg;
            p9_month_reg <= month_next;
        end
    end

    // stage 10: day of month, fields cleared when out of range
    d2g_date_t  out_reg;
    logic [8:0] dom;

    assign dom = p9_doy_reg - month_start(p9_month_reg, p9_leap_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.in_range <= p9_ok_reg;
            out_reg.year     <= p9_ok_reg ? p9_year_reg : '0;
            out_reg.month    <= p9_ok_reg ? (p9_month_reg + 4'd1) : '0;
            out_reg.day      <= p9_ok_reg ? (dom[4:0] + 5'd1) : '0;
        end
    end

    assign date = out_reg;

endmodule

### sv/day_number_to_gregorian_date.sv
// ============================================================================
// day_number_to_gregorian_date
// converts a proleptic gregorian day number (1 = 1 january of year 1) into
// year, month and day of month
// ============================================================================
// usage
// - input channel s_axis: one day number per transfer in tdata[21:0]
// - output channel m_axis: one date per input transfer, in input order
// - each date reaches tvalid on the output after passing all ten register stages
// - throughput is one transfer per cycle while the output is taken; ten register stages each hold
//   one item, so ten items may be in flight
// - day numbers of zero or past 31 december of MAX_YEAR give valid_res = 0
//   with year, month and day all zero
// - all stages advance together; when the output holds a date that the
//   receiver does not take, the whole pipeline halts and s_axis_tready drops,
//   so nothing is lost or repeated
// - s_axis_tready is high whenever the output register is empty or being
//   drained in the same cycle
// - reset clears every stage valid bit; payload registers are not reset
// - stage depth is set by the two constant-reciprocal multiplies, each
//   followed by its own multiply-subtract and correction stage
// ============================================================================
module day_number_to_gregorian_date #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // [21:0] day_number, [23:22] zero fill

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata     // [13:0] year_out, [17:14] month_out,
                                         // [22:18] day_out, [23] valid_res
);
    import d2g_pkg::*;

    // last valid day number: 31 december of MAX_YEAR
    localparam logic [31:0] LAST_DAY = 32'(365 * MAX_YEAR + MAX_YEAR / 4
                                         - MAX_YEAR / 100 + MAX_YEAR / 400);
    localparam int unsigned STAGES = 10;

    logic              en;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    d2g_date_t         date;

    // global advance: halt only when the output holds an untaken date
    assign en            = !vld_reg[STAGES-1] || m_axis_tready;
    assign s_axis_tready = en;

    // valid bits shift alongside the datapath stages
    assign vld_next = {vld_reg[STAGES-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    d2g_pipe #(
        .LAST_DAY (LAST_DAY)
    ) u_pipe (
        .clk        (clk),
        .en         (en),
        .day_number (s_axis_tdata[DAY_NUMBER_W-1:0]),
        .date       (date)
    );

    assign m_axis_tvalid = vld_reg[STAGES-1];
    assign m_axis_tdata  = {date.in_range, date.day, date.month, date.year};

endmodule

### sv/d2g_checker.sv
// ============================================================================
// d2g_checker
// port-level checks on the day number to gregorian date converter
// ============================================================================
module d2g_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // a stalled output transfer stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // an empty output never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // out of range dates carry zero fields
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[23] |-> m_axis_tdata[22:0] == 23'd0)
        else $error("invalid date with non-zero fields");

    // in range dates carry a real month and day
    a_valid_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[23] |->
            m_axis_tdata[17:14] != 4'd0 && m_axis_tdata[17:14] <= 4'd12
            && m_axis_tdata[22:18] != 5'd0 && m_axis_tdata[13:0] != 14'd0)
        else $error("valid date with out of range fields");

    // zero day number leads to an invalid result at the output when not stalled on its way through
    a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[21:0] == 22'd0
        && m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid && !m_axis_tdata[23])
        else $error("day number zero not reported invalid");

endmodule

bind day_number_to_gregorian_date d2g_checker u_d2g_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### bench/date_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// date_checker
// works out the calendar date for every day number taken on the input
// channel and compares each date transfer on the output channel with it
// ============================================================================
module date_checker #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [23:0] in_data,     // [21:0] day_number, [23:22] zero fill

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [23:0] out_data,    // [13:0] year_out, [17:14] month_out,
                                     // [22:18] day_out, [23] valid_res

    output int          mismatches,
    output int          pending,
    output int          dates_seen,
    output int          invalid_seen
);
    import d2g_pkg::*;

    localparam int unsigned LAST_VALID_DAY =
        365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;

    typedef struct {
        logic [DAY_NUMBER_W-1:0] day_number;
        d2g_date_t               date;
    } awaited_date_t;

    awaited_date_t awaited_dates[$];
    int            fail_total;
    int            seen_total;
    int            invalid_total;

    // proleptic gregorian calendar, split into 400, 100, 4 and 1 year spans
    function automatic d2g_date_t gregorian_of(input logic [DAY_NUMBER_W-1:0] day_number);
        int unsigned offset;
        int unsigned rest;
        int unsigned centuries;
        int unsigned quads;
        int unsigned years;
        int unsigned year;
        int unsigned month;
        int unsigned month_len;
        logic        leap;
        d2g_date_t   date;
        date = '0;
        if (day_number == '0 || day_number > LAST_VALID_DAY)
        begin
            return date;
        end
        offset    = day_number - 1;
        year      = (offset / DAYS_400Y) * 400;
        rest      = offset % DAYS_400Y;
        centuries = rest / DAYS_100Y;
        // last day of a 400 year cycle stays in the fourth century
        if (centuries > 3)
        begin
            centuries = 3;
        end
        rest  = rest - centuries * DAYS_100Y;
        quads = rest / DAYS_4Y;
        rest  = rest - quads * DAYS_4Y;
        years = rest / DAYS_1Y;
        // last day of a 4 year span is 31 december of its leap year
        if (years > 3)
        begin
            years = 3;
        end
        rest = rest - years * DAYS_1Y;
        year = year + centuries * 100 + quads * 4 + years + 1;
        leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
        for (month = 0; month < 11; month++)
        begin
            case (month)
                1:           month_len = leap ? 29 : 28;
                3, 5, 8, 10: month_len = 30;
                default:     month_len = 31;
            endcase
            if (rest < month_len)
            begin
                break;
            end
            rest = rest - month_len;
        end
        date.year     = YEAR_W'(year);
        date.month    = MONTH_W'(month + 1);
        date.day      = DAY_W'(rest + 1);
        date.in_range = 1'b1;
        return date;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        awaited_date_t head;
        d2g_date_t     got;
        if (!rst_n)
        begin
            awaited_dates.delete();
            fail_total    = 0;
            seen_total    = 0;
            invalid_total = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.year     = out_data[13:0];
                got.month    = out_data[17:14];
                got.day      = out_data[22:18];
                got.in_range = out_data[23];
                seen_total++;
                if (!got.in_range)
                begin
                    invalid_total++;
                end
                if (awaited_dates.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                    begin
                        $display("%t: date transfer with none awaited: %0d-%0d-%0d valid %0b",
                                 $realtime, got.year, got.month, got.day, got.in_range);
                    end
                end
                else
                begin
                    head = awaited_dates.pop_front();
                    if (got.year != head.date.year || got.month != head.date.month ||
                        got.day != head.date.day || got.in_range != head.date.in_range)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                        begin
                            $display("%t: day %0d: expected %0d-%0d-%0d/%0b got %0d-%0d-%0d/%0b",
                                     $realtime, head.day_number,
                                     head.date.year, head.date.month, head.date.day,
                                     head.date.in_range,
                                     got.year, got.month, got.day, got.in_range);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                awaited_dates.push_back('{day_number: in_data[21:0],
                                          date: gregorian_of(in_data[21:0])});
            end
        end
        mismatches   <= fail_total;
        pending      <= awaited_dates.size();
        dates_seen   <= seen_total;
        invalid_seen <= invalid_total;
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// drives day numbers into the date converter with random gaps and output
// stalls; a separate checker predicts every date and the top gives the verdict
// ============================================================================
module testbench;

    import d2g_pkg::*;

    localparam int unsigned MAX_YEAR     = 9999;
    localparam int          RANDOM_ITEMS = 1250;
    localparam int          QUIET_TAIL   = 150;     // last random items with no idling
    localparam int          CYCLE_LIMIT  = 300000;  // watchdog, far above the slowest run
    localparam int          DRAIN_CYCLES = 20;      // pipeline is ten stages deep

    logic        clk = 1'b0;
    logic        rst_n;

    // input channel, one day number per transfer
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;      // [21:0] day_number, [23:22] zero fill

    // output channel, one date per transfer
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;      // [13:0] year_out, [17:14] month_out,
                                    // [22:18] day_out, [23] valid_res

    // idling density, per hundred, set by phase of the run
    int          gap_pct   = 0;
    int          stall_pct = 0;

    int          sent_count = 0;
    int          cycle_count = 0;

    int          mismatches;
    int          pending;
    int          dates_seen;
    int          invalid_seen;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    day_number_to_gregorian_date #(
        .MAX_YEAR (MAX_YEAR)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    date_checker #(
        .MAX_YEAR (MAX_YEAR)
    ) date_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_data      (s_axis_tdata),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .mismatches   (mismatches),
        .pending      (pending),
        .dates_seen   (dates_seen),
        .invalid_seen (invalid_seen)
    );

    // day number of 1 january of the given year
    function automatic int unsigned first_day_of_year(input int unsigned year);
        int unsigned whole;
        whole = year - 1;
        return 365 * whole + whole / 4 - whole / 100 + whole / 400 + 1;
    endfunction

    // mostly real dates picked by year and day of year, leaning on leap and
    // century years and on month and year boundaries; the rest is spread over
    // the valid range and the whole 22 bit field
    function automatic logic [21:0] random_day_number(input int unsigned last_day);
        int unsigned mix;
        int unsigned year;
        int unsigned day_of_year;
        mix = $urandom_range(0, 99);
        if (mix < 60)
        begin
            case ($urandom_range(0, 4))
                0:       year = $urandom_range(1, MAX_YEAR);
                1:       year = 4 * $urandom_range(1, MAX_YEAR / 4);
                2:       year = 100 * $urandom_range(1, MAX_YEAR / 100);
                3:       year = 400 * $urandom_range(1, MAX_YEAR / 400);
                default: year = MAX_YEAR - $urandom_range(0, 3);
            endcase
            if ($urandom_range(0, 1))
            begin
                day_of_year = $urandom_range(0, 365);
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0:       day_of_year = 0;
                    1:       day_of_year = 30;
                    2:       day_of_year = 31;
                    3:       day_of_year = 58;
                    4:       day_of_year = 59;
                    5:       day_of_year = 60;
                    6:       day_of_year = 364;
                    default: day_of_year = 365;
                endcase
            end
            return 22'(first_day_of_year(year) + day_of_year);
        end
        else if (mix < 85)
        begin
            return 22'($urandom_range(1, last_day));
        end
        return 22'($urandom_range(0, 22'h3FFFFF));
    endfunction

    // one input transfer, entered and left at a falling edge
    task automatic send_day(input logic [21:0] day_number);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, day_number};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_count++;
        @(negedge clk);
    endtask

    // receiver: ready by default, stalls in bursts while stall_pct allows
    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d dates still awaited", cycle_count, pending);
        $display("** day_number_to_gregorian_date: FAILED **");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        int unsigned last_day;
        int unsigned directed_days[$];
        int          idx;
        int          phase;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        last_day      = first_day_of_year(MAX_YEAR + 1) - 1;

        // reset held low, then released at a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part: field extremes, month and year edges, the saturated
        // 4 year and 400 year spans, leap and century rules, out of range
        directed_days = '{0, 1, 31, 32, 59, 60, 365, 366,
                          1460, 1461, 1462, 36524, 36525,
                          146096, 146097, 146098,
                          first_day_of_year(1900) + 58, first_day_of_year(1900) + 59,
                          first_day_of_year(2000) + 59, first_day_of_year(2000) + 365,
                          last_day, last_day + 1,
                          22'h3FFFFF, 22'h2AAAAA, 22'h155555};
        foreach (directed_days[i])
        begin
            send_day(22'(directed_days[i]));
        end

        // random part, idling density changes every 125 transfers
        for (idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            phase = (idx / 125) % 4;
            if (idx >= RANDOM_ITEMS - QUIET_TAIL)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                case (phase)
                    0:       begin gap_pct = 0;  stall_pct = 20; end
                    1:       begin gap_pct = 25; stall_pct = 0;  end
                    2:       begin gap_pct = 10; stall_pct = 5;  end
                    default: begin gap_pct = 50; stall_pct = 40; end
                endcase
            end
            send_day(random_day_number(last_day));
        end
        s_axis_tvalid <= 1'b0;

        // let the pipeline drain
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d day numbers, %0d directed, and checked %0d dates, %0d out of range",
                 sent_count, directed_days.size(), dates_seen, invalid_seen);
        $display("%0d mismatching dates, %0d dates never delivered", mismatches, pending);
        if (mismatches == 0 && pending == 0)
        begin
            $display("** day_number_to_gregorian_date: PASSED **");
        end
        else
        begin
            $display("** day_number_to_gregorian_date: FAILED **");
        end
        $finish;
    end

endmodule
